// File: rtl/assert_macros.svh
// Assertion macros used by the checker of the project.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/srarq_pkg.sv
// Package for the selective-repeat endpoint: widths, codes, types and the window test.
// Depends on nothing; used by every RTL module of the block.
package srarq_pkg;

    localparam int SEQ_BITS     = 3;
    localparam int PAYLOAD_BITS = 32;
    localparam int NR_BUFS      = (1 << SEQ_BITS) / 2;
    localparam int SLOT_BITS    = SEQ_BITS - 1;
    localparam int CNT_BITS     = SEQ_BITS;
    localparam int S_DATA_BITS  = ((2 * PAYLOAD_BITS + 3 * SEQ_BITS + 7) / 8) * 8;
    localparam int S_USER_BITS  = 4;
    localparam int M_DATA_BITS  = ((PAYLOAD_BITS + 2 * SEQ_BITS + SLOT_BITS + 4 + 7) / 8) * 8;
    localparam int M_USER_BITS  = 3;

    typedef logic [SEQ_BITS-1:0]     seq_t;
    typedef logic [SLOT_BITS-1:0]    slot_t;
    typedef logic [PAYLOAD_BITS-1:0] payload_t;
    typedef logic [CNT_BITS-1:0]     cnt_t;

    // Event codes.
    typedef enum logic [2:0] {
        OP_NET_READY = 3'd0,
        OP_ARRIVAL   = 3'd1,
        OP_CKSUM_ERR = 3'd2,
        OP_TIMEOUT   = 3'd3,
        OP_ACK_TMO   = 3'd4
    } op_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_DELIVER,
        ST_FRAME,
        ST_STATUS
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic ack_step;
        logic deliver;
        logic emit_frame;
        logic emit_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       win_full;
        logic       ack_more;
        logic       deliver_more;
        logic       out_free;
    } stat_t;

    // True when b lies in the circular interval from a up to but not including c.
    function automatic logic in_window(input seq_t a, input seq_t b, input seq_t c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

endpackage

// File: rtl/srarq_ctrl.sv
// Controller state machine of the selective-repeat endpoint.
// Depends on srarq_pkg; drives the datapath through command signals only.
module srarq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  srarq_pkg::stat_t stat,
    output srarq_pkg::cmd_t  cmd
);
    import srarq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    case (stat.op)
                        OP_NET_READY: state_next = stat.win_full ? ST_STATUS : ST_FRAME;
                        OP_ARRIVAL:   state_next = ST_ACK;
                        OP_TIMEOUT:   state_next = ST_FRAME;
                        OP_ACK_TMO:   state_next = ST_FRAME;
                        default:      state_next = ST_STATUS;
                    endcase
                end
            end
            ST_ACK:
            begin
                // Piggybacked acks are taken first so every result sees the final count.
                if (stat.ack_more)
                begin
                    cmd.ack_step = 1'b1;
                end
                else
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!stat.deliver_more)
                begin
                    state_next = ST_STATUS;
                end
                else if (stat.out_free)
                begin
                    cmd.deliver = 1'b1;
                end
            end
            ST_FRAME:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_frame = 1'b1;
                    state_next     = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/srarq_dp.sv
// Datapath of the selective-repeat endpoint: window state, buffers and output register.
// Depends on srarq_pkg; steered by the commands of srarq_ctrl.
module srarq_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [srarq_pkg::S_DATA_BITS-1:0]   s_tdata,
    input  logic [srarq_pkg::S_USER_BITS-1:0]   s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [srarq_pkg::M_DATA_BITS-1:0]   m_tdata,
    output logic [srarq_pkg::M_USER_BITS-1:0]   m_tuser,
    output logic                                m_tlast,
    input  srarq_pkg::cmd_t                     cmd,
    output srarq_pkg::stat_t                    stat
);
    import srarq_pkg::*;

    // Unpacked request fields.
    logic [2:0] in_op;
    logic       in_is_data;
    payload_t   in_packet;
    seq_t       in_rseq;
    seq_t       in_rack;
    payload_t   in_payload;
    seq_t       in_tseq;

    assign in_op      = s_tuser[2:0];
    assign in_is_data = s_tuser[3];
    assign in_packet  = s_tdata[PAYLOAD_BITS-1:0];
    assign in_rseq    = s_tdata[PAYLOAD_BITS +: SEQ_BITS];
    assign in_rack    = s_tdata[PAYLOAD_BITS+SEQ_BITS +: SEQ_BITS];
    assign in_payload = s_tdata[PAYLOAD_BITS+2*SEQ_BITS +: PAYLOAD_BITS];
    assign in_tseq    = s_tdata[2*PAYLOAD_BITS+2*SEQ_BITS +: SEQ_BITS];

    // Window state.
    seq_t                ale_reg;
    seq_t                nss_reg;
    seq_t                es_reg;
    seq_t                rue_reg;
    cnt_t                cnt_reg;
    logic [NR_BUFS-1:0]  marks_reg;
    payload_t            out_store_reg [NR_BUFS];
    payload_t            in_store_reg  [NR_BUFS];

    // Per-event latches.
    seq_t                rack_reg;
    logic                fr_data_reg;
    seq_t                fr_seq_reg;

    // Output register.
    logic                m_valid_reg;
    logic [M_DATA_BITS-1:0] m_data_reg;
    logic [M_USER_BITS-1:0] m_user_reg;
    logic                m_last_reg;

    logic                win_full;
    logic                rx_ok;
    logic                out_free;
    logic                net_en;
    slot_t               es_slot;
    slot_t               fr_slot;
    seq_t                tx_ack;
    logic [M_DATA_BITS-1:0] m_data_new;
    logic [M_USER_BITS-1:0] m_user_new;

    assign win_full = (cnt_reg >= cnt_t'(NR_BUFS));
    assign net_en   = !win_full;
    assign rx_ok    = in_is_data && in_window(es_reg, in_rseq, rue_reg)
                      && !marks_reg[in_rseq[SLOT_BITS-1:0]];
    assign out_free = !m_valid_reg || m_tready;
    assign es_slot  = es_reg[SLOT_BITS-1:0];
    assign fr_slot  = fr_seq_reg[SLOT_BITS-1:0];
    assign tx_ack   = es_reg - seq_t'(1);

    assign stat.op           = in_op;
    assign stat.win_full     = win_full;
    assign stat.ack_more     = in_window(ale_reg, rack_reg, nss_reg);
    assign stat.deliver_more = marks_reg[es_slot];
    assign stat.out_free     = out_free;

    // Window edges, counters and arrival marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ale_reg   <= '0;
            nss_reg   <= '0;
            es_reg    <= '0;
            rue_reg   <= seq_t'(NR_BUFS);
            cnt_reg   <= '0;
            marks_reg <= '0;
        end
        else
        begin
            if (cmd.accept && (in_op == OP_NET_READY) && !win_full)
            begin
                cnt_reg <= cnt_reg + cnt_t'(1);
                nss_reg <= nss_reg + seq_t'(1);
            end
            if (cmd.accept && (in_op == OP_ARRIVAL) && rx_ok)
            begin
                marks_reg[in_rseq[SLOT_BITS-1:0]] <= 1'b1;
            end
            if (cmd.ack_step)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - cnt_t'(1);
                end
                ale_reg <= ale_reg + seq_t'(1);
            end
            if (cmd.deliver)
            begin
                marks_reg[es_slot] <= 1'b0;
                es_reg             <= es_reg + seq_t'(1);
                rue_reg            <= rue_reg + seq_t'(1);
            end
        end
    end

    // Buffers and per-event latches.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rack_reg <= in_rack;
            case (in_op)
                OP_NET_READY:
                begin
                    fr_data_reg <= 1'b1;
                    fr_seq_reg  <= nss_reg;
                    if (!win_full)
                    begin
                        out_store_reg[nss_reg[SLOT_BITS-1:0]] <= in_packet;
                    end
                end
                OP_TIMEOUT:
                begin
                    fr_data_reg <= 1'b1;
                    fr_seq_reg  <= in_tseq;
                end
                OP_ARRIVAL:
                begin
                    fr_data_reg <= 1'b0;
                    fr_seq_reg  <= '0;
                    if (rx_ok)
                    begin
                        in_store_reg[in_rseq[SLOT_BITS-1:0]] <= in_payload;
                    end
                end
                default:
                begin
                    fr_data_reg <= 1'b0;
                    fr_seq_reg  <= '0;
                end
            endcase
        end
    end

    // Result formatting: tx_seq, tx_ack, data_out, retx_start, timer_slot,
    // ack_tmr_start, net_enable from bit 0; tuser holds result_kind, tx_is_data.
    always_comb
    begin
        m_data_new = '0;
        m_user_new = '0;
        m_data_new[2*SEQ_BITS+PAYLOAD_BITS+SLOT_BITS+2] = net_en;
        if (cmd.emit_frame)
        begin
            m_user_new = {fr_data_reg, KIND_FRAME};
            m_data_new[SEQ_BITS +: SEQ_BITS] = tx_ack;
            if (fr_data_reg)
            begin
                m_data_new[SEQ_BITS-1:0]                        = fr_seq_reg;
                m_data_new[2*SEQ_BITS +: PAYLOAD_BITS]          = out_store_reg[fr_slot];
                m_data_new[2*SEQ_BITS+PAYLOAD_BITS]             = 1'b1;
                m_data_new[2*SEQ_BITS+PAYLOAD_BITS+1 +: SLOT_BITS] = fr_slot;
            end
        end
        else if (cmd.deliver)
        begin
            m_user_new = {1'b0, KIND_DELIVER};
            m_data_new[2*SEQ_BITS +: PAYLOAD_BITS]          = in_store_reg[es_slot];
            m_data_new[2*SEQ_BITS+PAYLOAD_BITS+SLOT_BITS+1] = 1'b1;
        end
        else
        begin
            m_user_new = {1'b0, KIND_STATUS};
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.emit_frame || cmd.deliver || cmd.emit_status)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_frame || cmd.deliver || cmd.emit_status)
        begin
            m_data_reg <= m_data_new;
            m_user_reg <= m_user_new;
            m_last_reg <= cmd.emit_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/selective_repeat_arq_endpoint_core.sv
// Selective-repeat endpoint: one event per request, up to five results each.
// An event is accepted in the idle state; an arrival then steps through each acknowledged
// frame and each in-order delivery, other events may emit one frame, and every event ends
// with the status result. A result waits while the output register is held. The next request
// is taken in the cycle after the status result enters the output register.
// Reset is asynchronous, active low, resets the windows and clears counters and arrival marks.
module selective_repeat_arq_endpoint_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // packet_in, rx_seq, rx_ack, rx_payload, timed_out_seq, zero padding
    input  logic [srarq_pkg::S_DATA_BITS-1:0]   s_tdata,
    // op, rx_is_data
    input  logic [srarq_pkg::S_USER_BITS-1:0]   s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tx_seq, tx_ack, data_out, retx_start, timer_slot, ack_tmr_start,
    // net_enable, zero padding
    output logic [srarq_pkg::M_DATA_BITS-1:0]   m_tdata,
    // result_kind, tx_is_data
    output logic [srarq_pkg::M_USER_BITS-1:0]   m_tuser,
    output logic                                m_tlast
);
    import srarq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    srarq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srarq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: rtl/srarq_checker.sv
// Port-level checks for the selective-repeat endpoint, bound to the top level.
// Depends on srarq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srarq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [srarq_pkg::M_DATA_BITS-1:0]   m_tdata,
    input logic [srarq_pkg::M_USER_BITS-1:0]   m_tuser,
    input logic                                m_tlast
);
    import srarq_pkg::*;

    // The final result of an event is exactly the status result.
    `ASSERT_SAME(a_last_is_status, m_tvalid, m_tlast == (m_tuser[1:0] == KIND_STATUS))

    // One event at a time: no request straight after an accepted one.
    `ASSERT_NEXT(a_one_event, s_tvalid && s_tready, !s_tready)

    // A delivery starts the ack timer and is never a data frame.
    `ASSERT_SAME(a_delivery, m_tvalid && (m_tuser[1:0] == KIND_DELIVER),
        m_tdata[2*SEQ_BITS+PAYLOAD_BITS+SLOT_BITS+1] && !m_tuser[2])

    // A stalled result holds.
    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind selective_repeat_arq_endpoint_core srarq_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
